// ===== hw/rtl/tpst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpst_pkg
// Shared types and constants of the tick-paced SPI transmitter.
// ----------------------------------------------------------------------------
package tpst_pkg;

  // Input word command codes, carried on tuser
  localparam logic CmdTick = 1'b0;
  localparam logic CmdXmit = 1'b1;

  // Configuration register map
  localparam int unsigned RegCount      = 1;
  localparam int unsigned AddrWidth     = 3;
  localparam logic        RegBitCount   = 1'b0;

  // Field widths
  localparam int unsigned WordWidth     = 32;
  localparam int unsigned BitCountWidth = 6;
  localparam logic [BitCountWidth-1:0] BitCountReset = 6'd8;

  // Result word layout on the master-side tdata
  localparam int unsigned PinsWidth     = 5;
  localparam int unsigned OutDataWidth  = 8;

  // Sequencer phases, one-hot
  typedef enum logic [7:0] {
    PhStop    = 8'b0000_0001,
    PhStart   = 8'b0000_0010,
    PhCsDown  = 8'b0000_0100,
    PhData    = 8'b0000_1000,
    PhClkUp   = 8'b0001_0000,
    PhDelay   = 8'b0010_0000,
    PhClkDown = 8'b0100_0000,
    PhCsUp    = 8'b1000_0000
  } tpst_phase_e;

  // Pin and status levels after one word, lowest field last
  typedef struct packed {
    logic pending;
    logic busy;
    logic mosi;
    logic sclk;
    logic cs_n;
  } tpst_pins_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tpst_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpst_apb_regs
// APB register block holding the bits-per-word setting, clamped on write.
// ----------------------------------------------------------------------------
module tpst_apb_regs
  import tpst_pkg::*;
#(
  parameter int unsigned MaxBits = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [AddrWidth-1:0]      paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [BitCountWidth-1:0]  bit_count_o
);

  localparam logic [BitCountWidth:0] MaxBitsW = (BitCountWidth+1)'(MaxBits);

  logic [BitCountWidth-1:0] bit_count_q, bit_count_d;
  logic [BitCountWidth-1:0] wr_val;
  logic                     reg_sel;
  logic                     wr_en;

  assign reg_sel = (paddr[AddrWidth-1] == RegBitCount);
  assign wr_en   = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;

  // Clamp the written value to 1..MaxBits
  always_comb begin
    wr_val = pwdata[BitCountWidth-1:0];
    if (wr_val == '0) begin
      wr_val = BitCountWidth'(1);
    end else if ({1'b0, wr_val} > MaxBitsW) begin
      wr_val = BitCountWidth'(MaxBits);
    end
  end

  assign bit_count_d = wr_en ? wr_val : bit_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= BitCountReset;
    end else begin
      bit_count_q <= bit_count_d;
    end
  end

  // Read back
  assign prdata      = reg_sel ? {{(32-BitCountWidth){1'b0}}, bit_count_q} : '0;
  assign bit_count_o = bit_count_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tpst_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpst_seq
// Phase sequencer: applies one tick or transmit request per step and
// reports the pin levels that follow.
// ----------------------------------------------------------------------------
module tpst_seq
  import tpst_pkg::*;
#(
  parameter int unsigned MaxBits = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     step_i,
  input  wire logic                     cmd_i,
  input  wire logic [WordWidth-1:0]     word_i,
  input  wire logic [BitCountWidth-1:0] bit_count_i,
  output tpst_pins_t                    pins_o
);

  localparam logic [MaxBits-1:0] MaskOne = MaxBits'(1);

  tpst_phase_e           phase_q, phase_d;
  logic [WordWidth-1:0]  shift_q, shift_d;
  logic [MaxBits-1:0]    mask_q, mask_d;
  logic [WordWidth-1:0]  held_q, held_d;
  logic                  held_vld_q, held_vld_d;
  logic                  cs_n_q, cs_n_d;
  logic                  sclk_q, sclk_d;
  logic                  mosi_q, mosi_d;
  logic [MaxBits-1:0]    word_ext;

  // Fit the shift word to the mask width
  always_comb begin
    word_ext = '0;
    for (int i = 0; i < MaxBits; i++) begin
      if (i < WordWidth) begin
        word_ext[i] = shift_q[i];
      end
    end
  end

  // Next state for one step
  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    mask_d     = mask_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    cs_n_d     = cs_n_q;
    sclk_d     = sclk_q;
    mosi_d     = mosi_q;
    if (step_i) begin
      if (cmd_i == CmdXmit) begin
        if (phase_q != PhStop) begin
          held_d     = word_i;
          held_vld_d = 1'b1;
        end else begin
          shift_d = word_i;
          phase_d = PhStart;
        end
      end else begin
        unique case (phase_q)
          PhStop: begin
          end
          PhStart: begin
            phase_d = PhCsDown;
          end
          PhCsDown: begin
            cs_n_d  = 1'b0;
            mask_d  = MaskOne << (bit_count_i - BitCountWidth'(1));
            phase_d = PhData;
          end
          PhData: begin
            mosi_d  = |(word_ext & mask_q);
            mask_d  = mask_q >> 1;
            phase_d = PhClkUp;
          end
          PhClkUp: begin
            sclk_d  = 1'b1;
            phase_d = PhDelay;
          end
          PhDelay: begin
            phase_d = PhClkDown;
          end
          PhClkDown: begin
            sclk_d  = 1'b0;
            phase_d = (mask_q == '0) ? PhCsUp : PhData;
          end
          PhCsUp: begin
            cs_n_d = 1'b1;
            if (held_vld_q) begin
              shift_d    = held_q;
              held_vld_d = 1'b0;
              phase_d    = PhCsDown;
            end else begin
              phase_d = PhStop;
            end
          end
          default: begin
            phase_d = PhStop;
          end
        endcase
      end
    end
  end

  // Control and pin state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhStop;
      held_vld_q <= 1'b0;
      cs_n_q     <= 1'b1;
      sclk_q     <= 1'b0;
      mosi_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      held_vld_q <= held_vld_d;
      cs_n_q     <= cs_n_d;
      sclk_q     <= sclk_d;
      mosi_q     <= mosi_d;
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    mask_q  <= mask_d;
    held_q  <= held_d;
  end

  // Levels after this step
  always_comb begin
    pins_o.cs_n    = cs_n_d;
    pins_o.sclk    = sclk_d;
    pins_o.mosi    = mosi_d;
    pins_o.busy    = (phase_d != PhStop);
    pins_o.pending = held_vld_d;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tick_paced_spi_transmitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tick_paced_spi_transmitter
// Transmit-only SPI master whose phases are paced by incoming tick words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis_*): one word per tick or transmit request. tuser
//   selects the kind (0 = tick, 1 = transmit), tdata carries the data word.
//   A transmit request while idle starts a word; while busy it replaces the
//   single held word. Each tick while busy moves the sequence one phase forward.
//   Master stream (m_axis_*): exactly one result word per input word, with
//   the CS, CLK and MOSI levels and the busy and pending flags after it.
//   APB port: register 0 at address 0 sets bits per word (1..MaxBits,
//   reset 8); write it only while no word is in flight.
// Timing:
//   The result is registered: an accepted word lands in the input register,
//   which feeds the sequencer step, and the step loads the output register
//   once that register is free or draining. Throughput is one word per
//   cycle while m_axis_tready stays high; the sequencer step is one phase
//   transition, so nothing iterates.
// Reset:
//   Both stream stages empty, phase stopped, CS high, CLK and MOSI low.
// Backpressure:
//   When m_axis_tready is low the result holds; the input register still
//   takes one more word, then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
module tick_paced_spi_transmitter
  import tpst_pkg::*;
#(
  parameter int unsigned MaxBits = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Slave stream
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [WordWidth-1:0]    s_axis_tdata,   // [31:0] word
  input  wire logic                    s_axis_tuser,   // [0] command
  // Master stream
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OutDataWidth-1:0]      m_axis_tdata,   // [0] chip_select_n,
                                                       // [1] serial_clock,
                                                       // [2] serial_data,
                                                       // [3] busy_res,
                                                       // [4] pending, [7:5] 0
  // APB configuration
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [AddrWidth-1:0]    paddr,
  input  wire logic [31:0]             pwdata,
  output logic      [31:0]             prdata,
  output logic                         pready
);

  logic                     in_vld_q, in_vld_d;
  logic                     in_cmd_q;
  logic [WordWidth-1:0]     in_word_q;
  logic                     out_vld_q, out_vld_d;
  tpst_pins_t               out_pins_q;
  tpst_pins_t               pins;
  logic [BitCountWidth-1:0] bit_count;
  logic                     s_fire;
  logic                     step;

  tpst_apb_regs #(
    .MaxBits (MaxBits)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .bit_count_o (bit_count)
  );

  // Handshake: step when the output register is free or draining
  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = s_fire ? 1'b1 : (step ? 1'b0 : in_vld_q);
  assign out_vld_d = step ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_cmd_q  <= s_axis_tuser;
      in_word_q <= s_axis_tdata;
    end
  end

  tpst_seq #(
    .MaxBits (MaxBits)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cmd_i       (in_cmd_q),
    .word_i      (in_word_q),
    .bit_count_i (bit_count),
    .pins_o      (pins)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_pins_q <= pins;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataWidth-PinsWidth){1'b0}}, out_pins_q};

endmodule
`default_nettype wire

// ===== hw/rtl/tpst_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpst_checker
// Port-level checks of the tick-paced SPI transmitter, bound to the top.
// ----------------------------------------------------------------------------
module tpst_checker
  import tpst_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [OutDataWidth-1:0] m_axis_tdata
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Idle means CS released and CLK low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[0] && !m_axis_tdata[1])
    else $error("pins active while idle");

  // A held word only exists during a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3])
    else $error("pending without busy");

  // CLK only pulses with CS asserted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("clock high with chip select released");

endmodule

bind tick_paced_spi_transmitter tpst_checker u_tpst_checker (.*);
`default_nettype wire
